### rtl/pcm_bytes_to_float_stereo_defines.svh
// assertion macros for the pcm byte to float stereo block
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef PCM_BYTES_TO_FLOAT_STEREO_DEFINES_SVH
`define PCM_BYTES_TO_FLOAT_STEREO_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PBF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pbf_pkg.sv
// shared constants and the integer to single precision conversion
// no dependencies
package pbf_pkg;

    localparam logic [1:0] REG_BYTES_PER_SAMPLE = 2'd0;
    localparam logic [1:0] REG_LITTLE_ENDIAN    = 2'd1;
    localparam logic [1:0] REG_FLOAT_SAMPLES    = 2'd2;
    localparam logic [1:0] REG_CHANNEL_COUNT    = 2'd3;

    localparam int CFG_WIDTH = 16;

    localparam logic [2:0]  BPS_RESET = 3'd2;
    localparam logic [15:0] NCH_RESET = 16'd2;

    typedef logic [31:0] t_word;

    // signed sample of nb bytes (1..4) scaled to [-1,1), round to nearest even
    function automatic t_word int_to_single(input t_word word, input logic [2:0] nb);
        logic [5:0]  bits;
        t_word       mask;
        t_word       u;
        logic        sgn;
        t_word       mag;
        logic [4:0]  p;
        logic [4:0]  s;
        t_word       rem;
        t_word       half;
        t_word       mant;
        logic [7:0]  biased;
        bits = {nb, 3'b000};
        case (nb)
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
        u   = word & mask;
        sgn = u[5'(bits - 6'd1)];
        if (sgn) begin
            u   = u | ~mask;
            mag = ~u + 32'd1;
        end else begin
            mag = u;
        end
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (mag[i]) begin
                p = 5'(i);
            end
        end
        biased = 8'(8'(p) + 8'd127 - 8'(bits - 6'd1));
        if (p <= 5'd23) begin
            mant = mag << (5'd23 - p);
        end else begin
            s    = p - 5'd23;
            rem  = mag & ((32'd1 << s) - 32'd1);
            half = 32'd1 << (s - 5'd1);
            mant = mag >> s;
            if (rem > half || (rem == half && mant[0])) begin
                mant = mant + 32'd1;
            end
        end
        if (mag == 32'd0) begin
            return 32'd0;
        end
        return {sgn, 31'd0} | (({24'd0, biased - 8'd1} << 23) + mant);
    endfunction

endpackage

### rtl/pcm_bytes_to_float_stereo.sv
// top level: byte assembly, conversion and stereo pair output
// depends on pbf_pkg and pcm_bytes_to_float_stereo_defines.svh

// Takes one byte of interleaved PCM sample data per transfer and emits one
// left/right pair of IEEE single precision words per completed frame. A new
// byte is taken every cycle unless the input is stalled: each byte is folded
// into the assembly register and, on the last byte of a sample, the sample is
// converted (sign extend, leading-one search, shift, round to nearest even) in
// the same cycle and stored into the held left/right registers. The output
// register decouples the sides; the input stalls only while a finished pair
// waits and the output side is stalled. The pair shows on the output in the
// cycle after the last byte of a frame. Registers are written through a plain
// write port; the user must do so only while the block is idle (not enforced).
`include "pcm_bytes_to_float_stereo_defines.svh"

module pcm_bytes_to_float_stereo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [pbf_pkg::CFG_WIDTH-1:0] i_cfg_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    // pair output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_left_sample,
    output logic [31:0] o_right_sample
);

    // configuration registers
    logic [2:0]  r_bps;
    logic        r_little;
    logic        r_float;
    logic [15:0] r_nch;

    // stream state
    logic [1:0]  r_byte_idx, n_byte_idx;
    logic [15:0] r_chan_idx, n_chan_idx;
    logic [31:0] r_asm, n_asm;
    logic [31:0] r_held_l, n_held_l;
    logic [31:0] r_held_r, n_held_r;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_l, n_out_l;
    logic [31:0] r_out_r, n_out_r;

    logic        in_xfer;
    logic [2:0]  nb_eff;
    logic [15:0] nch_eff;
    logic [1:0]  bi;
    logic [15:0] ci;
    logic [31:0] asm_cur;
    logic [31:0] asm_new;
    logic        sample_done;
    logic        frame_done;
    logic [31:0] conv;

    // stall input only when a pair waits and cannot leave
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // out-of-range widths clamp, zero channels means mono
    always_comb begin
        if (r_bps == 3'd0) begin
            nb_eff = 3'd1;
        end else if (r_bps > 3'd4) begin
            nb_eff = 3'd4;
        end else begin
            nb_eff = r_bps;
        end
        nch_eff = (r_nch == 16'd0) ? 16'd1 : r_nch;
    end

    always_comb begin
        // frame start clears alignment before the byte is taken
        bi      = i_frame_start ? 2'd0 : r_byte_idx;
        ci      = i_frame_start ? 16'd0 : r_chan_idx;
        asm_cur = i_frame_start ? 32'd0 : r_asm;
        if (r_little) begin
            asm_new = asm_cur | ({24'd0, i_data_byte} << {bi, 3'b000});
        end else begin
            asm_new = {asm_cur[23:0], i_data_byte};
        end
        sample_done = ({1'b0, bi} + 3'd1) >= nb_eff;
        frame_done  = ({1'b0, ci} + 17'd1) >= {1'b0, nch_eff};
        if (r_float && nb_eff == 3'd4) begin
            conv = asm_new;
        end else begin
            conv = pbf_pkg::int_to_single(asm_new, nb_eff);
        end

        n_byte_idx  = r_byte_idx;
        n_chan_idx  = r_chan_idx;
        n_asm       = r_asm;
        n_held_l    = r_held_l;
        n_held_r    = r_held_r;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;

        if (in_xfer) begin
            if (!sample_done) begin
                n_byte_idx = bi + 2'd1;
                n_chan_idx = ci;
                n_asm      = asm_new;
            end else begin
                n_byte_idx = 2'd0;
                n_asm      = 32'd0;
                // route the sample to its side
                if (nch_eff == 16'd1) begin
                    n_held_l = conv;
                    n_held_r = conv;
                end else if (ci == 16'd0) begin
                    n_held_l = conv;
                end else if (ci == 16'd1) begin
                    n_held_r = conv;
                end
                if (!frame_done) begin
                    n_chan_idx = ci + 16'd1;
                end else begin
                    n_chan_idx  = 16'd0;
                    n_out_valid = 1'b1;
                    n_out_l     = n_held_l;
                    n_out_r     = n_held_r;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps       <= pbf_pkg::BPS_RESET;
            r_little    <= 1'b0;
            r_float     <= 1'b0;
            r_nch       <= pbf_pkg::NCH_RESET;
            r_byte_idx  <= 2'd0;
            r_chan_idx  <= 16'd0;
            r_asm       <= 32'd0;
            r_held_l    <= 32'd0;
            r_held_r    <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    pbf_pkg::REG_BYTES_PER_SAMPLE: r_bps    <= i_cfg_data[2:0];
                    pbf_pkg::REG_LITTLE_ENDIAN:    r_little <= i_cfg_data[0];
                    pbf_pkg::REG_FLOAT_SAMPLES:    r_float  <= i_cfg_data[0];
                    pbf_pkg::REG_CHANNEL_COUNT:    r_nch    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_byte_idx  <= n_byte_idx;
            r_chan_idx  <= n_chan_idx;
            r_asm       <= n_asm;
            r_held_l    <= n_held_l;
            r_held_r    <= n_held_r;
            r_out_valid <= n_out_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out_l <= n_out_l;
        r_out_r <= n_out_r;
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_sample  = r_out_l;
    assign o_right_sample = r_out_r;

    // a waiting pair blocks new bytes
    `PBF_ASSERT_NOW(a_stall_when_full, r_out_valid && i_out_stall, o_in_stall, "input not stalled while pair waits")
    // a frame-completing byte yields a pair next cycle
    `PBF_ASSERT_NEXT(a_frame_gives_pair, in_xfer && sample_done && frame_done, o_out_valid, "completed frame produced no pair")

endmodule

### dv/pcm_bytes_to_float_stereo_tb.sv
`timescale 1ns / 100ps
// testbench for pcm_bytes_to_float_stereo: byte stream in, stereo float pairs out
// depends on pbf_pkg for the register indexes and reset values; self-checking against its own predictor

module pcm_bytes_to_float_stereo_tb;

    // predicts the stereo pairs from the accepted bytes and checks the ones that come out
    class pair_scoreboard;
        logic [2:0]  bps;
        logic        little;
        logic        float_mode;
        logic [15:0] nch;
        logic [1:0]  byte_pos;
        logic [15:0] chan_pos;
        logic [31:0] word;
        logic [31:0] held_l;
        logic [31:0] held_r;
        logic [63:0] pending_pairs[$];
        int          errors;

        function new();
            bps = pbf_pkg::BPS_RESET;
            little = 1'b0;
            float_mode = 1'b0;
            nch = pbf_pkg::NCH_RESET;
            byte_pos = '0;
            chan_pos = '0;
            word = '0;
            held_l = '0;
            held_r = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                pbf_pkg::REG_BYTES_PER_SAMPLE: bps = val[2:0];
                pbf_pkg::REG_LITTLE_ENDIAN:    little = val[0];
                pbf_pkg::REG_FLOAT_SAMPLES:    float_mode = val[0];
                pbf_pkg::REG_CHANNEL_COUNT:    nch = val;
                default: ;
            endcase
        endfunction

        // signed sample of nb bytes scaled to [-1,1), round half to even
        function logic [31:0] sample_to_single(logic [31:0] w, int nb);
            int          bits;
            logic [31:0] mask;
            logic [31:0] x;
            logic        sgn;
            logic [32:0] mag;
            logic [32:0] m;
            logic [32:0] rem;
            logic [32:0] half;
            int          p;
            int          s;
            int          e;
            bits = 8 * nb;
            mask = (nb == 4) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
            x = w & mask;
            sgn = x[bits - 1];
            if (sgn) begin
                x = x | ~mask;
                mag = {1'b0, ~x} + 33'd1;
            end else begin
                mag = {1'b0, x};
            end
            if (mag == 33'd0) begin
                return 32'd0;
            end
            p = 0;
            for (int i = 0; i < 33; i++) begin
                if (mag[i]) begin
                    p = i;
                end
            end
            e = p + 127 - (bits - 1);
            if (p <= 23) begin
                m = mag << (23 - p);
            end else begin
                s = p - 23;
                m = mag >> s;
                rem = mag & ((33'd1 << s) - 33'd1);
                half = 33'd1 << (s - 1);
                if (rem > half || (rem == half && m[0])) begin
                    m = m + 33'd1;
                end
            end
            // rounding carried into bit 24
            if (m[24]) begin
                m = m >> 1;
                e = e + 1;
            end
            return {sgn, e[7:0], m[22:0]};
        endfunction

        function void note_byte(logic [7:0] b, logic fs);
            int          nb;
            int          n;
            logic [31:0] v;
            nb = (bps == 3'd0) ? 1 : (bps > 3'd4) ? 4 : int'(bps);
            n = (nch == 16'd0) ? 1 : int'(nch);
            if (fs) begin
                byte_pos = '0;
                chan_pos = '0;
                word = '0;
            end
            if (little) begin
                word = word | ({24'd0, b} << (8 * byte_pos));
            end else begin
                word = {word[23:0], b};
            end
            if (int'(byte_pos) + 1 < nb) begin
                byte_pos = byte_pos + 2'd1;
                return;
            end
            v = (float_mode && nb == 4) ? word : sample_to_single(word, nb);
            byte_pos = '0;
            word = '0;
            if (n == 1) begin
                held_l = v;
                held_r = v;
            end else if (chan_pos == 16'd0) begin
                held_l = v;
            end else if (chan_pos == 16'd1) begin
                held_r = v;
            end
            if (int'(chan_pos) + 1 < n) begin
                chan_pos = chan_pos + 16'd1;
                return;
            end
            chan_pos = '0;
            pending_pairs.push_back({held_l, held_r});
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void check_pair(logic [31:0] l, logic [31:0] r);
            logic [63:0] exp_pair;
            if (pending_pairs.size() == 0) begin
                report($sformatf("unexpected pair l=%h r=%h", l, r));
                return;
            end
            exp_pair = pending_pairs.pop_front();
            if (l !== exp_pair[63:32]) begin
                report($sformatf("left got %h want %h", l, exp_pair[63:32]));
            end
            if (r !== exp_pair[31:0]) begin
                report($sformatf("right got %h want %h", r, exp_pair[31:0]));
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_frame_start;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_left_sample;
    logic [31:0] o_right_sample;

    pair_scoreboard sb;
    bit             quiet;       // no idling on either side while set
    bit             byte_moved;  // a transfer happens at the coming edge
    bit             pair_moved;
    int             idle_cycles;

    pcm_bytes_to_float_stereo uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_data_byte(i_data_byte),
        .i_frame_start(i_frame_start),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_left_sample(o_left_sample),
        .o_right_sample(o_right_sample)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // bytes lean toward the ones that hit the conversion extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // output side stall pattern, registered at the clock edge
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // outputs are stable mid-cycle, so transfers are decided at the falling edge
    always @(negedge i_clk) begin
        byte_moved = i_rst_n && i_in_valid && !o_in_stall;
        pair_moved = i_rst_n && o_out_valid && !i_out_stall;
        if (byte_moved) begin
            sb.note_byte(i_data_byte, i_frame_start);
        end
        if (pair_moved) begin
            sb.check_pair(o_left_sample, o_right_sample);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if (!i_rst_n || byte_moved || pair_moved || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic fs);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_frame_start <= fs;
        // look at the handshake itself, not at the sampler's flag
        forever begin
            @(negedge i_clk);
            if (i_in_valid && !o_in_stall) begin
                break;
            end
        end
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        // let the output register settle, plus margin
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_mode(int bps, int le, int fl, int nch);
        wait_drained();
        write_reg(pbf_pkg::REG_BYTES_PER_SAMPLE, 16'(bps));
        write_reg(pbf_pkg::REG_LITTLE_ENDIAN, 16'(le));
        write_reg(pbf_pkg::REG_FLOAT_SAMPLES, 16'(fl));
        write_reg(pbf_pkg::REG_CHANNEL_COUNT, 16'(nch));
    endtask

    // well-formed frames with random content, plus stray frame starts and cut frames
    task automatic run_frames(int frames);
        int nb;
        int n;
        int len;
        nb = (sb.bps == 3'd0) ? 1 : (sb.bps > 3'd4) ? 4 : int'(sb.bps);
        n = (sb.nch == 16'd0) ? 1 : int'(sb.nch);
        for (int f = 0; f < frames; f++) begin
            len = nb * n;
            if ($urandom_range(0, 19) == 0) begin
                len = $urandom_range(1, len);
            end
            for (int k = 0; k < len; k++) begin
                if (k == 0) begin
                    send_byte(pick_byte(), $urandom_range(0, 7) != 0);
                end else begin
                    send_byte(pick_byte(), $urandom_range(0, 49) == 0);
                end
            end
        end
    endtask

    initial begin
        int bps;
        int nch;
        sb = new();
        quiet = 1'b0;
        byte_moved = 1'b0;
        pair_moved = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_frame_start = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: 16-bit big-endian stereo, full scale and zero
        send_byte(8'h7F, 1'b1); send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1); send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1); send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h01, 1'b0);
        // restart in the middle of a frame
        send_byte(8'h12, 1'b1); send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1); send_byte(8'h78, 1'b0);
        send_byte(8'h9A, 1'b0); send_byte(8'hBC, 1'b0);

        // 32-bit integer extremes, little-endian mono
        set_mode(4, 1, 0, 1);
        send_byte(8'h00, 1'b1); send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1); send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'h7F, 1'b0);

        // fixed settings: width and channel extremes, out-of-range codes, float mode
        quiet = 1'b1;
        set_mode(1, 0, 0, 0);  run_frames(40);
        quiet = 1'b0;
        set_mode(0, 1, 0, 2);  run_frames(30);
        set_mode(3, 0, 0, 2);  run_frames(15);
        set_mode(3, 1, 0, 3);  run_frames(10);
        set_mode(4, 0, 1, 2);  run_frames(12);
        set_mode(4, 1, 1, 1);  run_frames(20);
        set_mode(2, 1, 1, 2);  run_frames(20);
        set_mode(7, 0, 0, 2);  run_frames(10);
        set_mode(5, 1, 1, 3);  run_frames(8);
        set_mode(2, 0, 0, 6);  run_frames(8);

        // random settings, small channel counts
        for (int ph = 0; ph < 4; ph++) begin
            quiet = ($urandom_range(0, 3) == 0);
            bps = $urandom_range(0, 7);
            nch = $urandom_range(0, 4);
            set_mode(bps, $urandom_range(0, 1), $urandom_range(0, 1), nch);
            run_frames(60 / (((bps == 0) ? 1 : (bps > 4) ? 4 : bps) *
                             ((nch == 0) ? 1 : nch)) + 2);
        end

        // widest channel count, the start of a frame of single bytes
        quiet = 1'b1;
        set_mode(1, 0, 0, 65535);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b0);
        for (int k = 2; k < 40; k++) begin
            send_byte(8'($urandom), 1'b0);
        end
        quiet = 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.pending_pairs.size() == 0 && sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/pbf_pkg.sv
rtl/pcm_bytes_to_float_stereo.sv
dv/pcm_bytes_to_float_stereo_tb.sv
